@@ src/mountain_removal_lis_lds_top_assert.svh @@
// ----------------------------------------------------------------------------
// Mountain removal assertion macros
// Shared property macros for the block's checker.
// ----------------------------------------------------------------------------
`ifndef MOUNTAIN_REMOVAL_LIS_LDS_TOP_ASSERT_SVH
`define MOUNTAIN_REMOVAL_LIS_LDS_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define MRL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mountain removal assertion failed");

// next-cycle implication
`define MRL_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mountain removal assertion failed");

`endif

@@ src/mrl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrl_pkg
// Types and constants for the mountain removal block.
// ----------------------------------------------------------------------------
package mrl_pkg;

   localparam int MAX_LEN    = 1024;
   localparam int VALUE_BITS = 32;
   localparam int IDX_W      = $clog2(MAX_LEN);
   localparam int CNT_W      = IDX_W + 1;

   localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_LEN);
   localparam logic [CNT_W-1:0] NONE_FOUND = '1;
   localparam logic [CNT_W-1:0] SHORT_LEN  = CNT_W'(3);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         last;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] removals;
      logic             found;
      logic             overflow;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_PLACE,
      ST_FALL,
      ST_NEXT,
      ST_LOAD,
      ST_DONE
   } state_type;

endpackage

@@ src/mountain_removal_lis_lds_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mountain_removal_lis_lds_top
// Minimum removals to make a sequence a mountain, by patience sorting.
// ----------------------------------------------------------------------------
// Items carry one signed value each; the item with last set closes the
// sequence and yields one result item. Each stored value is placed in a tails
// memory by a binary search run on one shared compare unit: every search step
// is a memory read, then a compare, and req_stall is high while an item is
// placed. After the last item the block walks the stored values backwards with
// the same search unit (unless exactly three values are stored, which gives
// zero removals directly), then holds the result until it is taken. Up to 1024
// values are stored; further items are dropped and flagged as overflow.
module mountain_removal_lis_lds_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mrl_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mrl_pkg::rsp_item_type rsp_item
);
   import mrl_pkg::*;

   // memories
   logic signed [VALUE_BITS-1:0] value_mem [MAX_LEN];
   logic signed [VALUE_BITS-1:0] tails_mem [MAX_LEN];
   logic [CNT_W-1:0]             rise_mem  [MAX_LEN];

   logic signed [VALUE_BITS-1:0] value_rd_ff, tails_rd_ff;
   logic [CNT_W-1:0]             rise_rd_ff;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CNT_W-1:0] tails_count_ff, tails_count_in;
   logic [CNT_W-1:0] element_count_ff, element_count_in;
   logic [CNT_W-1:0] best_ff, best_in, idx_ff, idx_in;
   logic             overflow_ff, overflow_in, last_ff, last_in, fall_ff, fall_in;
   logic signed [VALUE_BITS-1:0] key_ff, key_in;

   logic             value_we, tails_we, rise_we, fetch_re, probe_re;
   logic [IDX_W-1:0] fetch_addr;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] len, cost;
   logic [CNT_W:0]   cost_wide;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign len       = lo_ff + CNT_W'(1);
   assign cost_wide = {1'b0, element_count_ff} + (CNT_W+1)'(1)
                      - {1'b0, rise_rd_ff} - {1'b0, len};
   assign cost      = cost_wide[CNT_W-1:0];

   // sequencer: search steps, placement and the backward walk
   always_comb begin
      state_in         = state_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      mid_in           = mid_ff;
      tails_count_in   = tails_count_ff;
      element_count_in = element_count_ff;
      best_in          = best_ff;
      idx_in           = idx_ff;
      overflow_in      = overflow_ff;
      last_in          = last_ff;
      fall_in          = fall_ff;
      key_in           = key_ff;
      value_we         = 1'b0;
      tails_we         = 1'b0;
      rise_we          = 1'b0;
      fetch_re         = 1'b0;
      probe_re         = 1'b0;
      fetch_addr       = idx_ff[IDX_W-1:0] - IDX_W'(1);
      req_stall        = 1'b1;
      rsp_valid        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               last_in = req_item.last;
               if (element_count_ff < MAX_CNT) begin
                  value_we = 1'b1;
                  key_in   = req_item.value;
                  lo_in    = '0;
                  hi_in    = tails_count_ff;
                  fall_in  = 1'b0;
                  state_in = ST_PROBE;
               end else begin
                  overflow_in = 1'b1;
                  if (req_item.last) begin
                     state_in = ST_FALL;
                  end
               end
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[CNT_W:1];
               probe_re = 1'b1;
               state_in = ST_CMP;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_CMP: begin
            if (tails_rd_ff < key_ff) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_PROBE;
         end
         ST_PLACE: begin
            if (lo_ff < MAX_CNT) begin
               tails_we = 1'b1;
               if (lo_ff == tails_count_ff) begin
                  tails_count_in = tails_count_ff + CNT_W'(1);
               end
            end
            if (!fall_ff) begin
               rise_we          = 1'b1;
               element_count_in = element_count_ff + CNT_W'(1);
               state_in         = last_ff ? ST_FALL : ST_IDLE;
            end else begin
               if (rise_rd_ff > CNT_W'(1) && len > CNT_W'(1) && cost < best_ff) begin
                  best_in = cost;
               end
               state_in = ST_NEXT;
            end
         end
         ST_FALL: begin
            if (element_count_ff == SHORT_LEN) begin
               best_in  = '0;
               state_in = ST_DONE;
            end else begin
               tails_count_in = '0;
               idx_in         = element_count_ff;
               fall_in        = 1'b1;
               state_in       = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (idx_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               fetch_re = 1'b1;
               idx_in   = idx_ff - CNT_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            key_in   = value_rd_ff;
            lo_in    = '0;
            hi_in    = tails_count_ff;
            state_in = ST_PROBE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               tails_count_in   = '0;
               element_count_in = '0;
               best_in          = NONE_FOUND;
               overflow_in      = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result item, held while in the done state
   assign rsp_item.found    = (best_ff != NONE_FOUND);
   assign rsp_item.removals = rsp_item.found ? best_ff : '0;
   assign rsp_item.overflow = overflow_ff;

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         tails_count_ff   <= '0;
         element_count_ff <= '0;
         best_ff          <= NONE_FOUND;
         overflow_ff      <= 1'b0;
         last_ff          <= 1'b0;
         fall_ff          <= 1'b0;
      end else begin
         state_ff         <= state_in;
         tails_count_ff   <= tails_count_in;
         element_count_ff <= element_count_in;
         best_ff          <= best_in;
         overflow_ff      <= overflow_in;
         last_ff          <= last_in;
         fall_ff          <= fall_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      idx_ff <= idx_in;
      key_ff <= key_in;
   end

   // value and rise memories: write on store, read on backward walk
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[element_count_ff[IDX_W-1:0]] <= req_item.value;
      end
      if (rise_we) begin
         rise_mem[element_count_ff[IDX_W-1:0]] <= len;
      end
      if (fetch_re) begin
         value_rd_ff <= value_mem[fetch_addr];
         rise_rd_ff  <= rise_mem[fetch_addr];
      end
   end

   // tails memory: probe read, place write
   always_ff @(posedge clock) begin
      if (tails_we) begin
         tails_mem[lo_ff[IDX_W-1:0]] <= key_ff;
      end
      if (probe_re) begin
         tails_rd_ff <= tails_mem[mid_in[IDX_W-1:0]];
      end
   end

endmodule

@@ src/mrl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrl_checker
// Port-level checks for the mountain removal block, bound to the top level.
// ----------------------------------------------------------------------------
`include "mountain_removal_lis_lds_top_assert.svh"

module mrl_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input mrl_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input mrl_pkg::rsp_item_type rsp_item
);
   import mrl_pkg::*;

   // a stalled result item holds
   `MRL_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))
   // no peak means zero removals
   `MRL_ASSERT_IMP(a_none_zero, rsp_valid && !rsp_item.found, rsp_item.removals == '0)
   // no new item while a result waits
   `MRL_ASSERT_IMP(a_busy_rsp, rsp_valid, req_stall)
   // an accepted closing item makes the block busy
   `MRL_ASSERT_NXT(a_last_busy, req_valid && !req_stall && req_item.last, req_stall)

endmodule

bind mountain_removal_lis_lds_top mrl_checker u_mrl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
